// File: sv/lbhc_pkg.sv
package lbhc_pkg;

    localparam logic [1:0] ITEM_TICK    = 2'd0;
    localparam logic [1:0] ITEM_ADVANCE = 2'd1;
    localparam logic [1:0] ITEM_SELECT  = 2'd2;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned BEAT_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAT_PERIOD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAT_TOGGLES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAT_LENGTH  = 3'd4;

    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET  = 16'd100;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET  = 16'd1000;
    localparam logic [PERIOD_W-1:0] BEAT_PERIOD_RESET  = 16'd200;
    localparam logic [BEAT_W-1:0]   BEAT_TOGGLES_RESET = 5'd4;
    localparam logic [BEAT_W-1:0]   BEAT_LENGTH_RESET  = 5'd20;

    typedef struct packed {
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] beat_period;
        logic [BEAT_W-1:0]   beat_toggles;
        logic [BEAT_W-1:0]   beat_length;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic advance;
    } led_ctrl_t;

    typedef struct packed {
        logic       tick;
        logic       select;
        logic [1:0] selection;
    } ind_ctrl_t;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        eff_period = (p == '0) ? PERIOD_W'(1) : p;
    endfunction

endpackage

// File: sv/lbhc_req_if.sv
interface lbhc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] led_number;
    logic [1:0] selection;

    modport source (output valid, output mode, output led_number, output selection,
                    input ready);
    modport sink   (input valid, input mode, input led_number, input selection,
                    output ready);
endinterface

// File: sv/lbhc_rsp_if.sv
interface lbhc_rsp_if #(
    parameter int LED_COUNT = 3
);
    logic                 valid;
    logic                 ready;
    logic [LED_COUNT-1:0] led_levels;
    logic                 indicator_level;

    modport source (output valid, output led_levels, output indicator_level, input ready);
    modport sink   (input valid, input led_levels, input indicator_level, output ready);
endinterface

// File: sv/lbhc_led_unit.sv
module lbhc_led_unit
    import lbhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  led_ctrl_t ctrl,
    output logic      level_next
);

    localparam logic [2:0] M_OFF  = 3'd0;
    localparam logic [2:0] M_FAST = 3'd1;
    localparam logic [2:0] M_SLOW = 3'd2;
    localparam logic [2:0] M_BEAT = 3'd3;
    localparam logic [2:0] M_ON   = 3'd4;

    logic [2:0]          mode_reg,  mode_next;
    logic                level_reg;
    logic [PERIOD_W-1:0] cnt_reg,   cnt_next;
    logic [BEAT_W-1:0]   beat_reg,  beat_next;
    logic [PERIOD_W-1:0] cnt_dec;
    logic [BEAT_W-1:0]   beat_inc;
    logic [2:0]          mode_adv;

    function automatic logic [PERIOD_W-1:0] period_of(input logic [2:0] m, input cfg_t c);
        if (m == M_SLOW)
            period_of = eff_period(c.slow_period);
        else if (m == M_BEAT)
            period_of = eff_period(c.beat_period);
        else
            period_of = eff_period(c.fast_period);
    endfunction

    assign cnt_dec  = cnt_reg - PERIOD_W'(1);
    assign beat_inc = beat_reg + BEAT_W'(1);
    assign mode_adv = (mode_reg >= M_ON) ? M_OFF : mode_reg + 3'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        level_next = level_reg;
        cnt_next   = cnt_reg;
        beat_next  = beat_reg;
        if (ctrl.tick)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    cnt_next = period_of(mode_reg, cfg);
                    if (mode_reg == M_BEAT)
                    begin
                        beat_next = beat_inc;
                        if (beat_inc <= cfg.beat_toggles)
                            level_next = ~level_reg;
                        if (beat_inc >= cfg.beat_length)
                            beat_next = '0;
                    end
                    else
                    begin
                        level_next = ~level_reg;
                    end
                end
            end
        end
        else if (ctrl.advance)
        begin
            mode_next = mode_adv;
            cnt_next  = '0;
            unique case (mode_adv) inside
                M_OFF:
                begin
                    level_next = 1'b0;
                end
                M_ON:
                begin
                    level_next = 1'b1;
                end
                M_FAST, M_SLOW, M_BEAT:
                begin
                    level_next = (mode_adv == M_BEAT) ? 1'b0 : ~level_reg;
                    beat_next  = '0;
                    cnt_next   = period_of(mode_adv, cfg);
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_OFF;
            level_reg <= 1'b0;
            cnt_reg   <= '0;
            beat_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
            beat_reg  <= beat_next;
        end
    end

endmodule

// File: sv/lbhc_indicator.sv
module lbhc_indicator
    import lbhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  ind_ctrl_t ctrl,
    output logic      level_next
);

    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_ON   = 2'd1;
    localparam logic [1:0] SEL_FAST = 2'd2;
    localparam logic [1:0] SEL_SLOW = 2'd3;

    logic [1:0]          sel_reg, sel_next;
    logic                state_reg;
    logic [PERIOD_W-1:0] cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] cnt_dec;

    assign cnt_dec = cnt_reg - PERIOD_W'(1);

    always_comb
    begin
        sel_next   = sel_reg;
        level_next = state_reg;
        cnt_next   = cnt_reg;
        if (ctrl.tick)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    level_next = ~state_reg;
                    cnt_next   = (sel_reg == SEL_SLOW) ? eff_period(cfg.slow_period)
                                                       : eff_period(cfg.fast_period);
                end
            end
        end
        else if (ctrl.select)
        begin
            sel_next = ctrl.selection;
            cnt_next = '0;
            unique case (ctrl.selection)
                SEL_NONE: level_next = 1'b0;
                SEL_ON:   level_next = 1'b1;
                SEL_FAST:
                begin
                    level_next = ~state_reg;
                    cnt_next   = eff_period(cfg.fast_period);
                end
                SEL_SLOW:
                begin
                    level_next = ~state_reg;
                    cnt_next   = eff_period(cfg.slow_period);
                end
                default:  level_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= SEL_NONE;
            state_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            sel_reg   <= sel_next;
            state_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/led_blink_heartbeat_controller.sv
// LED blink and heartbeat controller.
// req carries one item per transfer: a millisecond tick, a request to advance
// the mode of one LED, or a new selection for the indicator. rsp returns one
// transfer per item with all LED levels and the indicator level after it.
// Registers must be written through cfg_wr_en/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. Writes to an index
// above four are dropped. An accepted item is held in the input register, then
// the LED units and the indicator update their state and the levels land in
// the result register, which drives rsp.valid.
// Throughput is one item per cycle while rsp does not stall; every timer
// updates in parallel in one pass of logic between the input register and the
// result register. When rsp stalls, the result register holds and the input
// register takes one more item; req.ready drops once both are full.
// Reset clears all LEDs to off, stops all timers, clears the indicator and
// loads the register defaults (100, 1000, 200, 4, 20).
module led_blink_heartbeat_controller
    import lbhc_pkg::*;
#(
    parameter int LED_COUNT = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    lbhc_req_if.sink               req,
    lbhc_rsp_if.source             rsp,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                 cfg_reg;
    logic                 in_valid_reg;
    logic [1:0]           mode_reg;
    logic [1:0]           num_reg;
    logic [1:0]           sel_reg;
    logic                 out_valid_reg;
    logic [LED_COUNT-1:0] levels_reg;
    logic                 ind_reg;
    logic [LED_COUNT-1:0] levels_next;
    logic                 ind_next;
    logic                 advance;
    logic                 step;
    ind_ctrl_t            ind_ctrl;

    assign advance   = !out_valid_reg || rsp.ready;
    assign step      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_period  <= FAST_PERIOD_RESET;
            cfg_reg.slow_period  <= SLOW_PERIOD_RESET;
            cfg_reg.beat_period  <= BEAT_PERIOD_RESET;
            cfg_reg.beat_toggles <= BEAT_TOGGLES_RESET;
            cfg_reg.beat_length  <= BEAT_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FAST_PERIOD:  cfg_reg.fast_period  <= cfg_data;
                REG_SLOW_PERIOD:  cfg_reg.slow_period  <= cfg_data;
                REG_BEAT_PERIOD:  cfg_reg.beat_period  <= cfg_data;
                REG_BEAT_TOGGLES: cfg_reg.beat_toggles <= cfg_data[BEAT_W-1:0];
                REG_BEAT_LENGTH:  cfg_reg.beat_length  <= cfg_data[BEAT_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.valid && req.ready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg <= req.mode;
            num_reg  <= req.led_number;
            sel_reg  <= req.selection;
        end
    end

    genvar i;
    generate
        for (i = 0; i < LED_COUNT; i++)
        begin : g_led
            led_ctrl_t led_ctrl;

            assign led_ctrl.tick    = step && (mode_reg == ITEM_TICK);
            assign led_ctrl.advance = step && (mode_reg == ITEM_ADVANCE)
                                      && (32'(num_reg) == 32'(i + 1));

            lbhc_led_unit u_led (
                .clk        (clk),
                .rst_n      (rst_n),
                .cfg        (cfg_reg),
                .ctrl       (led_ctrl),
                .level_next (levels_next[i])
            );
        end
    endgenerate

    assign ind_ctrl.tick      = step && (mode_reg == ITEM_TICK);
    assign ind_ctrl.select    = step && (mode_reg == ITEM_SELECT);
    assign ind_ctrl.selection = sel_reg;

    lbhc_indicator u_ind (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ctrl       (ind_ctrl),
        .level_next (ind_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            levels_reg <= levels_next;
            ind_reg    <= ind_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.led_levels      = levels_reg;
    assign rsp.indicator_level = ind_reg;

endmodule
